@@ hdl/aes_pkg.sv @@
// Package: AES-128 types, S-box, round helpers and constants.
`timescale 1ns / 1ps
package aes_pkg;

    localparam int NumRounds = 10;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_out_item;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } t_reg_idx;

    // Forward S-box
    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // Round constants for rounds 1..10
    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36
    };

    // Byte i of a 128-bit word, byte 0 most significant
    function automatic t_byte get_byte(input logic [127:0] w, input int i);
        get_byte = w[127-8*i -: 8];
    endfunction

    function automatic t_byte gf_double(input t_byte v);
        gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    // Next round key from current key and round constant
    function automatic logic [127:0] next_key(input logic [127:0] k, input t_byte rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
              SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

    // SubBytes and ShiftRows together
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        t_byte a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4*c);
            a1  = get_byte(s, 4*c+1);
            a2  = get_byte(s, 4*c+2);
            a3  = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127-8*(4*c)   -: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
            t[127-8*(4*c+1) -: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
            t[127-8*(4*c+2) -: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
            t[127-8*(4*c+3) -: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
        mix_columns = t;
    endfunction

endpackage

@@ hdl/aes128_block_encrypt.sv @@
// Top level: AES-128 encryption pipeline with key registers and a registered output stage.
`timescale 1ns / 1ps
// Fully unrolled AES-128 encryptor: one input stage doing the initial key
// addition, then ten round stages, each a register, eleven register stages
// in all. One block is taken every cycle while the pipeline advances. The
// whole pipeline advances whenever the output register is empty or being
// drained, so throughput is one block per cycle under a ready sink. The key
// is read at the input stage and carried with each block; write keys only
// while idle.
module aes128_block_encrypt
    import aes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    logic [63:0]  r_key_high, r_key_low;
    logic         w_en;
    logic         r_v0;
    logic [127:0] r_s0, r_k0;
    logic         w_v   [NumRounds+1];
    logic [127:0] w_s   [NumRounds+1];
    logic [127:0] w_k   [NumRounds+1];

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Pipeline moves when the last stage is empty or its result is taken
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // Input stage: initial AddRoundKey
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
        end
        if (w_en) begin
            r_s0 <= {i_data.plain_high, i_data.plain_low} ^ {r_key_high, r_key_low};
            r_k0 <= {r_key_high, r_key_low};
        end
    end

    assign w_v[0] = r_v0;
    assign w_s[0] = r_s0;
    assign w_k[0] = r_k0;

    // Ten round stages
    for (genvar g = 0; g < NumRounds; g++) begin : g_round
        aes_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_state (w_s[g]),
            .i_key   (w_k[g]),
            .i_rcon  (RCON[g]),
            .i_last  (g == NumRounds - 1),
            .o_valid (w_v[g+1]),
            .o_state (w_s[g+1]),
            .o_key   (w_k[g+1])
        );
    end

    assign o_valid            = w_v[NumRounds];
    assign o_data.cipher_high = w_s[NumRounds][127:64];
    assign o_data.cipher_low  = w_s[NumRounds][63:0];

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed under stall");

    // Input taken exactly when the pipeline advances
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready mismatch");

    // A transfer in reaches the first stage
    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v0)
        else $error("accepted block lost at entry");

endmodule

@@ hdl/aes_round.sv @@
// One registered AES round with its own key expansion step.
`timescale 1ns / 1ps
module aes_round
    import aes_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    input  t_byte        i_rcon,
    input  logic         i_last,
    output logic         o_valid,
    output logic [127:0] o_state,
    output logic [127:0] o_key
);

    logic [127:0] n_state, n_key, w_sub;
    logic         r_valid;
    logic [127:0] r_state, r_key;

    // Round function
    always_comb begin
        n_key   = next_key(i_key, i_rcon);
        w_sub   = sub_shift(i_state);
        n_state = (i_last ? w_sub : mix_columns(w_sub)) ^ n_key;
    end

    // Stage register, advances only when the pipeline moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

@@ tb/tb_aes128_block_encrypt.sv @@
// Testbench for the AES-128 block encryptor: directed and random traffic checked against a behavioural cipher.
`timescale 1ns / 1ps
module tb_aes128_block_encrypt;
    import aes_pkg::*;

    localparam int Latency  = 11;
    localparam int WdogLimit = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_data;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_data;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    aes128_block_encrypt DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Clock, low first so the first rising edge comes after set-up
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Behavioural cipher state
    logic [63:0] key_hi_q = '0;
    logic [63:0] key_lo_q = '0;

    t_in_item  plain_queue[$];
    t_out_item cipher_queue[$];

    int n_errors     = 0;
    int send_idle_pc = 0;
    int recv_idle_pc = 0;
    int idle_cycles  = 0;

    // Stand-alone S-box, built from the GF(2^8) inverse and the affine map
    logic [7:0] sub_table [256];

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = xtime(a);
        end
        return p;
    endfunction

    initial begin
        logic [7:0] inv, x;
        for (int v = 0; v < 256; v++) begin
            inv = 8'h00;
            for (int u = 1; u < 256; u++)
                if (gmul(8'(v), 8'(u)) == 8'h01) inv = 8'(u);
            x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_table[v] = x;
        end
    end

    // Full encryption of one block under the current key
    function automatic t_out_item encrypt_block(input t_in_item p);
        logic [7:0] st [16];
        logic [7:0] rk [16];
        logic [7:0] tmp [16];
        logic [7:0] rcon, a0, a1, a2, a3, all, t0;
        logic [127:0] blk, kw;
        t_out_item res;
        blk  = {p.plain_high, p.plain_low};
        kw   = {key_hi_q, key_lo_q};
        rcon = 8'h01;
        for (int i = 0; i < 16; i++) begin
            st[i] = blk[127-8*i -: 8] ^ kw[127-8*i -: 8];
            rk[i] = kw[127-8*i -: 8];
        end
        for (int rnd = 1; rnd <= 10; rnd++) begin
            // key schedule step
            t0 = sub_table[rk[13]] ^ rcon;
            tmp[1] = sub_table[rk[14]];
            tmp[2] = sub_table[rk[15]];
            tmp[3] = sub_table[rk[12]];
            rk[0] ^= t0;
            rk[1] ^= tmp[1];
            rk[2] ^= tmp[2];
            rk[3] ^= tmp[3];
            for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
            rcon = xtime(rcon);
            // SubBytes and ShiftRows
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[r+4*c] = sub_table[st[r + 4*((c+r)%4)]];
            // MixColumns except in the last round
            for (int c = 0; c < 4; c++) begin
                a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
                if (rnd != 10) begin
                    all = a0 ^ a1 ^ a2 ^ a3;
                    st[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                    st[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                    st[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                    st[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
                end else begin
                    st[4*c] = a0; st[4*c+1] = a1; st[4*c+2] = a2; st[4*c+3] = a3;
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= rk[i];
        end
        for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = st[i];
        res.cipher_high = blk[127:64];
        res.cipher_low  = blk[63:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    endtask

    // Driver: sends pending plaintext blocks, predicting each on transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) cipher_queue.push_back(encrypt_block(i_data));
            if (plain_queue.size() > 0 && $urandom_range(99) >= send_idle_pc) begin
                i_valid <= 1'b1;
                i_data  <= plain_queue.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks ciphertext transfers, throttles ready
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (cipher_queue.size() == 0) begin
                    report_mismatch("unexpected block", o_data.cipher_high, '0);
                end else begin
                    want = cipher_queue.pop_front();
                    if (o_data.cipher_high !== want.cipher_high)
                        report_mismatch("cipher_high", o_data.cipher_high, want.cipher_high);
                    if (o_data.cipher_low !== want.cipher_low)
                        report_mismatch("cipher_low", o_data.cipher_low, want.cipher_low);
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pc);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WdogLimit) begin
            $display("FAIL aes128_block_encrypt");
            $finish;
        end
    end

    task automatic push_plain(input logic [63:0] hi, input logic [63:0] lo);
        t_in_item p;
        p.plain_high = hi;
        p.plain_low  = lo;
        plain_queue.push_back(p);
    endtask

    // Wait for every queued block to go out and every result to come back
    task automatic drain;
        while (plain_queue.size() > 0 || i_valid || cipher_queue.size() > 0)
            @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    // One write, then the write enable is dropped so back-to-back writes never collide
    task automatic write_key(input t_reg_idx idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_KEY_HIGH) key_hi_q = val;
        else                     key_lo_q = val;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random blocks, with some single-bit and all-but-one-bit patterns mixed in
    task automatic push_random(input int count);
        logic [63:0] hi, lo;
        for (int n = 0; n < count; n++) begin
            hi = rand64();
            lo = rand64();
            case ($urandom_range(9))
                0: hi = 64'h1 << $urandom_range(63);
                1: lo = ~(64'h1 << $urandom_range(63));
                default: ;
            endcase
            push_plain(hi, lo);
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_ready    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_KEY_HIGH;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset key, then FIPS-197 appendix key, then extremes
        push_plain('0, '0);
        push_plain('1, '1);
        drain();
        write_key(REG_KEY_HIGH, 64'h0001020304050607);
        write_key(REG_KEY_LOW,  64'h08090a0b0c0d0e0f);
        push_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
        push_plain('0, '0);
        push_plain('1, '1);
        push_plain(64'h8000000000000000, 64'h0000000000000001);
        drain();
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW,  '1);
        push_plain('0, '0);
        push_plain('1, '1);
        push_plain(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
        drain();

        // Random phase one: sender idles lightly, receiver heavily
        send_idle_pc = 12;
        recv_idle_pc = 68;
        write_key(REG_KEY_HIGH, rand64());
        write_key(REG_KEY_LOW,  rand64());
        push_random(140);
        drain();
        write_key(REG_KEY_LOW, '0);
        push_random(140);
        drain();

        // Phase two: the other way round
        send_idle_pc = 68;
        recv_idle_pc = 12;
        write_key(REG_KEY_HIGH, '0);
        write_key(REG_KEY_LOW,  rand64());
        push_random(140);
        drain();
        write_key(REG_KEY_HIGH, rand64());
        push_random(140);
        drain();

        // Phase three: no idling at all
        send_idle_pc = 0;
        recv_idle_pc = 0;
        write_key(REG_KEY_HIGH, rand64());
        write_key(REG_KEY_LOW,  rand64());
        push_random(140);
        drain();
        write_key(REG_KEY_HIGH, rand64());
        write_key(REG_KEY_LOW,  rand64());
        push_random(140);
        drain();

        if (n_errors == 0)
            $display("PASS aes128_block_encrypt");
        else
            $display("FAIL aes128_block_encrypt");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/aes_pkg.sv
hdl/aes_round.sv
hdl/aes128_block_encrypt.sv
tb/tb_aes128_block_encrypt.sv
